// ----- design/dlt_pkg.sv -----
package dlt_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 16;

    localparam int MAC_W   = 64;
    localparam int SHORT_W = 16;
    localparam int CMD_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 3;

    localparam logic [BYTE_W-1:0] BEAT_STEP      = 8'd2;
    localparam logic [BYTE_W-1:0] MISS_LIMIT_RST = 8'd3;

    // Command bytes that update the table.
    localparam logic [CMD_W-1:0] CMD_DATA_A = 8'd0;
    localparam logic [CMD_W-1:0] CMD_DATA_B = 8'd2;

    localparam logic KIND_MSG  = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    localparam logic [STAT_W-1:0] ST_HIT_MAC   = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_HIT_SHORT = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd4;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd5;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd6;

    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [SHORT_W-1:0] short_a;
        logic [BYTE_W-1:0]  beat;
        logic [BYTE_W-1:0]  snap;
        logic [BYTE_W-1:0]  miss;
    } t_entry;

endpackage

// ----- design/dlt_msg_if.sv -----
interface dlt_msg_if
    import dlt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [CMD_W-1:0]   cmd_byte;
    logic               mac_known;
    logic [MAC_W-1:0]   ext_addr;
    logic [SHORT_W-1:0] short_addr;

    modport source (output valid, kind, cmd_byte, mac_known, ext_addr, short_addr,
                    input ready);
    modport sink   (input valid, kind, cmd_byte, mac_known, ext_addr, short_addr,
                    output ready);
endinterface

// ----- design/dlt_res_if.sv -----
interface dlt_res_if
    import dlt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic               removed_valid;
    logic [MAC_W-1:0]   removed_ext_addr;
    logic [SHORT_W-1:0] removed_short_addr;
    logic               last;

    modport source (output valid, status, removed_valid, removed_ext_addr,
                    removed_short_addr, last, input ready);
    modport sink   (input valid, status, removed_valid, removed_ext_addr,
                    removed_short_addr, last, output ready);
endinterface

// ----- design/dlt_cfg_if.sv -----
interface dlt_cfg_if
    import dlt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- design/dlt_entry_ram.sv -----
module dlt_entry_ram
    import dlt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_entry           i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_entry           o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // Read data holds while no read is issued, so a stalled walk keeps its entry.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/device_liveness_table.sv -----
// Channel   Dir  Modport  Handshake      Beat carries
// i_msg     in   sink     valid / ready  kind, cmd_byte, mac_known, ext_addr, short_addr
// o_res     out  source   valid / ready  status, removed_valid, removed_ext_addr,
//                                        removed_short_addr, last
// i_cfg     in   sink     valid / ready  data (miss_limit), ready is always high
//
// A message walks the entry memory one read per cycle, over the N entries in use,
// until the first match. A scan walks it the same way, but stalls while a removal
// beat waits for the result channel. Either kind also waits in its closing step
// while an earlier result beat still sits unaccepted in the output register. An
// item whose command byte is ignored goes from idle straight to its closing step.
// Reset clears the entry count and the miss limit returns to 3; the memory itself
// is not cleared, since only places below the count are read. A new input beat is
// taken whenever the block is idle, even while the last result beat still waits in
// the output register.
module device_liveness_table
    import dlt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dlt_msg_if.sink   i_msg,
    dlt_res_if.source o_res,
    dlt_cfg_if.sink   i_cfg
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Control state.
    logic [1:0]        r_state,     n_state;
    logic [CNT_W-1:0]  r_total,     n_total;
    logic [CNT_W-1:0]  r_rd_cnt,    n_rd_cnt;
    logic [CNT_W-1:0]  r_wr_cnt,    n_wr_cnt;
    logic              r_ev_valid,  n_ev_valid;
    logic [IDX_W-1:0]  r_ev_idx,    n_ev_idx;
    logic [STAT_W-1:0] r_status,    n_status;
    logic [BYTE_W-1:0] r_limit;
    logic              r_out_valid, n_out_valid;

    // Latched input beat.
    logic               r_mac_known, n_mac_known;
    logic [MAC_W-1:0]   r_ext,       n_ext;
    logic [SHORT_W-1:0] r_short,     n_short;

    // Output payload.
    logic [STAT_W-1:0]  r_out_status,  n_out_status;
    logic               r_out_rm,      n_out_rm;
    logic [MAC_W-1:0]   r_out_mac,     n_out_mac;
    logic [SHORT_W-1:0] r_out_short,   n_out_short;
    logic               r_out_last,    n_out_last;

    // Memory port signals.
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_entry           wr_data;
    t_entry           rd_data;

    t_entry            scan_entry;
    logic [BYTE_W-1:0] miss_inc;
    logic              beat_same;
    logic              ev_remove;
    logic              msg_match;
    logic              can_push;
    logic              more;
    logic              stall;
    logic              push;
    logic              push_rm;

    dlt_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    // Aging of the entry under evaluation during a scan. The miss count
    // saturates, and an unchanged beat count since the last scan is a miss.
    always_comb begin
        miss_inc   = (rd_data.miss == '1) ? rd_data.miss : rd_data.miss + 1'b1;
        beat_same  = (rd_data.beat == rd_data.snap);
        scan_entry = rd_data;
        if (beat_same) begin
            scan_entry.miss = miss_inc;
        end else begin
            scan_entry.snap = rd_data.beat;
            scan_entry.miss = '0;
        end
    end

    assign can_push  = !r_out_valid || o_res.ready;
    assign more      = (r_rd_cnt < r_total);
    assign rd_idx    = r_rd_cnt[IDX_W-1:0];
    assign ev_remove = (r_state == S_SCAN) && r_ev_valid && (scan_entry.miss >= r_limit);
    assign stall     = ev_remove && !can_push;
    assign msg_match = (r_state == S_WALK) && r_ev_valid &&
                       (r_mac_known ? (rd_data.mac == r_ext) : (rd_data.short_a == r_short));

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_rd_cnt    = r_rd_cnt;
        n_wr_cnt    = r_wr_cnt;
        n_ev_valid  = r_ev_valid;
        n_ev_idx    = r_ev_idx;
        n_status    = r_status;
        n_mac_known = r_mac_known;
        n_ext       = r_ext;
        n_short     = r_short;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = r_ev_idx;
        wr_data     = rd_data;
        push        = 1'b0;
        push_rm     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_msg.valid) begin
                    n_mac_known = i_msg.mac_known;
                    n_ext       = i_msg.ext_addr;
                    n_short     = i_msg.short_addr;
                    n_rd_cnt    = '0;
                    n_wr_cnt    = '0;
                    n_ev_valid  = 1'b0;
                    if (i_msg.kind == KIND_SCAN) begin
                        n_state = S_SCAN;
                    end else if (i_msg.cmd_byte == CMD_DATA_A ||
                                 i_msg.cmd_byte == CMD_DATA_B) begin
                        n_state = S_WALK;
                    end else begin
                        n_status = ST_IGNORED;
                        n_state  = S_DONE;
                    end
                end
            end
            S_WALK: begin
                // Reads stream one per cycle; the first matching entry wins and
                // any read already in flight behind it is dropped.
                if (msg_match) begin
                    wr_en        = 1'b1;
                    wr_data.beat = rd_data.beat + BEAT_STEP;
                    n_status     = r_mac_known ? ST_HIT_MAC : ST_HIT_SHORT;
                    n_ev_valid   = 1'b0;
                    n_state      = S_DONE;
                end else if (more) begin
                    rd_en      = 1'b1;
                    n_rd_cnt   = r_rd_cnt + 1'b1;
                    n_ev_valid = 1'b1;
                    n_ev_idx   = rd_idx;
                end else if (r_ev_valid) begin
                    n_ev_valid = 1'b0;
                end else begin
                    n_state = S_DONE;
                    if (!r_mac_known) begin
                        n_status = ST_UNKNOWN;
                    end else if (r_total == CNT_W'(TABLE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en           = 1'b1;
                        wr_idx          = r_total[IDX_W-1:0];
                        wr_data.mac     = r_ext;
                        wr_data.short_a = r_short;
                        wr_data.beat    = '0;
                        wr_data.snap    = '0;
                        wr_data.miss    = '0;
                        n_total         = r_total + 1'b1;
                        n_status        = ST_INSERTED;
                    end
                end
            end
            S_SCAN: begin
                // Survivors are written back compacted at the write count, which
                // never passes the read count, so no pending read is disturbed.
                if (r_ev_valid && !stall) begin
                    if (ev_remove) begin
                        push    = 1'b1;
                        push_rm = 1'b1;
                    end else begin
                        wr_en    = 1'b1;
                        wr_idx   = r_wr_cnt[IDX_W-1:0];
                        wr_data  = scan_entry;
                        n_wr_cnt = r_wr_cnt + 1'b1;
                    end
                end
                if (!stall) begin
                    if (more) begin
                        rd_en      = 1'b1;
                        n_rd_cnt   = r_rd_cnt + 1'b1;
                        n_ev_valid = 1'b1;
                    end else begin
                        n_ev_valid = 1'b0;
                        if (!r_ev_valid) begin
                            n_total  = r_wr_cnt;
                            n_status = ST_REMOVED;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (can_push) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: a pushed beat replaces one that is being taken.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_rm     = r_out_rm;
        n_out_mac    = r_out_mac;
        n_out_short  = r_out_short;
        n_out_last   = r_out_last;
        if (push) begin
            n_out_valid  = 1'b1;
            n_out_status = push_rm ? ST_REMOVED : r_status;
            n_out_rm     = push_rm;
            n_out_mac    = push_rm ? rd_data.mac : '0;
            n_out_short  = push_rm ? rd_data.short_a : '0;
            n_out_last   = !push_rm;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_rd_cnt    <= '0;
            r_wr_cnt    <= '0;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= MISS_LIMIT_RST;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_rd_cnt    <= n_rd_cnt;
            r_wr_cnt    <= n_wr_cnt;
            r_ev_valid  <= n_ev_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx     <= n_ev_idx;
        r_status     <= n_status;
        r_mac_known  <= n_mac_known;
        r_ext        <= n_ext;
        r_short      <= n_short;
        r_out_status <= n_out_status;
        r_out_rm     <= n_out_rm;
        r_out_mac    <= n_out_mac;
        r_out_short  <= n_out_short;
        r_out_last   <= n_out_last;
    end

    assign i_msg.ready              = (r_state == S_IDLE);
    assign i_cfg.ready              = 1'b1;
    assign o_res.valid              = r_out_valid;
    assign o_res.status             = r_out_status;
    assign o_res.removed_valid      = r_out_rm;
    assign o_res.removed_ext_addr   = r_out_mac;
    assign o_res.removed_short_addr = r_out_short;
    assign o_res.last               = r_out_last;

endmodule

// ----- design/dlt_checker.sv -----
module dlt_checker
    import dlt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic [STAT_W-1:0]  i_res_status,
    input logic               i_res_removed_valid,
    input logic [MAC_W-1:0]   i_res_removed_ext_addr,
    input logic [SHORT_W-1:0] i_res_removed_short_addr,
    input logic               i_res_last
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_status) &&
        $stable(i_res_last) && $stable(i_res_removed_ext_addr))
        else $error("result beat changed while stalled");

    a_removed_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_removed_valid |-> i_res_status == ST_REMOVED && !i_res_last)
        else $error("removal beat with wrong status or last flag");

    a_final_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_removed_valid |-> i_res_last &&
        i_res_removed_ext_addr == '0 && i_res_removed_short_addr == '0)
        else $error("closing beat not marked last or carries an address");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_status <= ST_REMOVED)
        else $error("status code out of range");

endmodule

bind device_liveness_table dlt_checker u_dlt_checker (
    .i_clk                    (i_clk),
    .i_rst_n                  (i_rst_n),
    .i_res_valid              (o_res.valid),
    .i_res_ready              (o_res.ready),
    .i_res_status             (o_res.status),
    .i_res_removed_valid      (o_res.removed_valid),
    .i_res_removed_ext_addr   (o_res.removed_ext_addr),
    .i_res_removed_short_addr (o_res.removed_short_addr),
    .i_res_last               (o_res.last)
);

// ----- bench/dlt_liveness_check.sv -----
`timescale 1ns / 1ps

// Watches the message, result and limit channels of the liveness table. It keeps
// its own copy of the table and of the miss limit. For every accepted input beat
// it queues the result beats that the table must return, and it compares each
// accepted result beat with the oldest one queued.
module dlt_liveness_check
    import dlt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dlt_msg_if   msg_ch,
    dlt_res_if   res_ch,
    dlt_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_removals
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               removed_valid;
        logic [MAC_W-1:0]   removed_ext_addr;
        logic [SHORT_W-1:0] removed_short_addr;
        logic               last;
    } t_reply;

    t_entry            devices [DEPTH];
    int                dev_count;
    logic [BYTE_W-1:0] limit_now;
    t_reply            expected_replies[$];
    int                fail_total    = 0;
    int                checked_total = 0;
    int                removal_total = 0;

    // Looks up the sender of a message, updates its entry and returns the status.
    function automatic logic [STAT_W-1:0] lookup_sender(input logic [CMD_W-1:0] cmd,
                                                        input logic known,
                                                        input logic [MAC_W-1:0] mac,
                                                        input logic [SHORT_W-1:0] shrt);
        if (cmd != CMD_DATA_A && cmd != CMD_DATA_B) begin
            return ST_IGNORED;
        end
        if (known) begin
            for (int i = 0; i < dev_count; i++) begin
                if (devices[i].mac == mac) begin
                    devices[i].beat = devices[i].beat + BEAT_STEP;
                    return ST_HIT_MAC;
                end
            end
            if (dev_count >= DEPTH) begin
                return ST_FULL;
            end
            devices[dev_count] = '{mac: mac, short_a: shrt, beat: '0, snap: '0, miss: '0};
            dev_count++;
            return ST_INSERTED;
        end
        for (int i = 0; i < dev_count; i++) begin
            if (devices[i].short_a == shrt) begin
                devices[i].beat = devices[i].beat + BEAT_STEP;
                return ST_HIT_SHORT;
            end
        end
        return ST_UNKNOWN;
    endfunction

    // One scan tick: ages every entry, drops the silent ones and queues a beat
    // for each drop, then the closing beat.
    function automatic void age_table();
        int i;
        i = 0;
        while (i < dev_count) begin
            if (devices[i].beat == devices[i].snap) begin
                if (devices[i].miss != 8'hFF) begin
                    devices[i].miss = devices[i].miss + 8'd1;
                end
            end else begin
                devices[i].snap = devices[i].beat;
                devices[i].miss = '0;
            end
            if (devices[i].miss >= limit_now) begin
                expected_replies.push_back('{status: ST_REMOVED, removed_valid: 1'b1,
                                             removed_ext_addr: devices[i].mac,
                                             removed_short_addr: devices[i].short_a,
                                             last: 1'b0});
                for (int j = i; j + 1 < dev_count; j++) begin
                    devices[j] = devices[j + 1];
                end
                dev_count--;
            end else begin
                i++;
            end
        end
        expected_replies.push_back('{status: ST_REMOVED, removed_valid: 1'b0,
                                     removed_ext_addr: '0, removed_short_addr: '0,
                                     last: 1'b1});
    endfunction

    task automatic field_diff(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    task automatic check_beat();
        t_reply want;
        if (expected_replies.size() == 0) begin
            $error("result beat with nothing expected: status %0d, last %0b",
                   res_ch.status, res_ch.last);
            fail_total++;
        end else begin
            want = expected_replies.pop_front();
            checked_total++;
            if (want.removed_valid) begin
                removal_total++;
            end
            field_diff("status", 64'(want.status), 64'(res_ch.status));
            field_diff("removed_valid", 64'(want.removed_valid), 64'(res_ch.removed_valid));
            field_diff("removed_ext_addr", want.removed_ext_addr, res_ch.removed_ext_addr);
            field_diff("removed_short_addr", 64'(want.removed_short_addr),
                       64'(res_ch.removed_short_addr));
            field_diff("last", 64'(want.last), 64'(res_ch.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dev_count = 0;
            limit_now = MISS_LIMIT_RST;
            expected_replies.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                check_beat();
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                limit_now = cfg_ch.data;
            end
            if (msg_ch.valid && msg_ch.ready) begin
                if (msg_ch.kind == KIND_SCAN) begin
                    age_table();
                end else begin
                    expected_replies.push_back('{
                        status: lookup_sender(msg_ch.cmd_byte, msg_ch.mac_known,
                                              msg_ch.ext_addr, msg_ch.short_addr),
                        removed_valid: 1'b0, removed_ext_addr: '0,
                        removed_short_addr: '0, last: 1'b1});
                end
            end
        end
        o_pending    <= expected_replies.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
        o_removals   <= removal_total;
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the device liveness table. The checker beside the
// block does all prediction and comparison; this module only sends beats, drives
// the result ready, writes the miss limit between phases and reports the outcome.
module tb
    import dlt_pkg::*;
;

    localparam int POOL_SIZE  = 24;
    localparam int IDLE_GUARD = 4;

    localparam logic [MAC_W-1:0] MAC_ZERO = 64'h0;
    localparam logic [MAC_W-1:0] MAC_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [MAC_W-1:0] MAC_C    = 64'h0123_4567_89AB_CDEF;
    localparam logic [MAC_W-1:0] MAC_D    = 64'hFEDC_BA98_7654_3210;
    localparam logic [SHORT_W-1:0] SHORT_SHARED = 16'h5AA5;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dlt_msg_if msg_ch ();
    dlt_res_if res_ch ();
    dlt_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int checked;
    int removals;

    int items_sent  = 0;
    int limit_writes = 0;
    int burst_left  = 0;

    // Known devices that the random traffic keeps coming back to. There are more
    // of them than table places, so the table fills up and reports full.
    logic [MAC_W-1:0]   pool_mac   [POOL_SIZE];
    logic [SHORT_W-1:0] pool_short [POOL_SIZE];

    device_liveness_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    dlt_liveness_check checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .msg_ch       (msg_ch),
        .res_ch       (res_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_removals   (removals)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The result side stalls on a rotating 16-bit ready pattern. Every so often
    // a new pattern is chosen: always ready, random, or sparse (long stalls).
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age   = 0;

    always @(posedge i_clk) begin
        if (pattern_age == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    ready_pattern = 16'hFFFF;
                end
                1: begin
                    ready_pattern = 16'($urandom) | 16'h0001;
                end
                default: begin
                    ready_pattern = (16'($urandom) & 16'($urandom)) | 16'h8000;
                end
            endcase
            pattern_age = $urandom_range(40, 200);
        end
        pattern_age--;
        res_ch.ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    // Sends one beat on the message channel. The sender works in bursts; when a
    // burst is used up it drops valid for a random gap before the next one.
    task automatic send_beat(input logic kind, input logic [CMD_W-1:0] cmd,
                             input logic known, input logic [MAC_W-1:0] mac,
                             input logic [SHORT_W-1:0] shrt);
        if (burst_left == 0) begin
            msg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        msg_ch.valid      <= 1'b1;
        msg_ch.kind       <= kind;
        msg_ch.cmd_byte   <= cmd;
        msg_ch.mac_known  <= known;
        msg_ch.ext_addr   <= mac;
        msg_ch.short_addr <= shrt;
        @(posedge i_clk);
        while (!msg_ch.ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // A scan beat; its payload is don't-care, so it carries random bits.
    task automatic send_scan();
        send_beat(KIND_SCAN, 8'($urandom), 1'($urandom), {$urandom, $urandom},
                  16'($urandom));
    endtask

    // Holds the sender until every expected result beat has come back and the
    // block has settled, so that the limit can be rewritten safely.
    task automatic wait_idle();
        msg_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [BYTE_W-1:0] limit);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= limit;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        limit_writes++;
        @(posedge i_clk);
    endtask

    // Mostly heartbeats from pool devices with random content, plus scans at the
    // given rate, ignored command bytes and strangers as noise.
    task automatic random_traffic(input int count, input int scan_pct);
        int roll;
        int pick;
        logic [CMD_W-1:0] cmd;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, POOL_SIZE - 1);
            cmd  = ($urandom_range(0, 1) != 0) ? CMD_DATA_B : CMD_DATA_A;
            if (roll < scan_pct) begin
                send_scan();
            end else if (roll < scan_pct + 8) begin
                cmd = 8'($urandom);
                if (cmd == CMD_DATA_A || cmd == CMD_DATA_B) begin
                    cmd = cmd | 8'h01;
                end
                send_beat(KIND_MSG, cmd, 1'($urandom), {$urandom, $urandom},
                          16'($urandom));
            end else if (roll < scan_pct + 14) begin
                send_beat(KIND_MSG, cmd, 1'($urandom), {$urandom, $urandom},
                          16'($urandom));
            end else if ($urandom_range(0, 3) == 0) begin
                // Extended address not resolved: the short address must match.
                send_beat(KIND_MSG, cmd, 1'b0, {$urandom, $urandom}, pool_short[pick]);
            end else begin
                send_beat(KIND_MSG, cmd, 1'b1, pool_mac[pick], pool_short[pick]);
            end
        end
    endtask

    initial begin
        msg_ch.valid      = 1'b0;
        msg_ch.kind       = KIND_MSG;
        msg_ch.cmd_byte   = '0;
        msg_ch.mac_known  = 1'b0;
        msg_ch.ext_addr   = '0;
        msg_ch.short_addr = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_mac[i]   = {$urandom, $urandom};
            pool_short[i] = 16'($urandom);
        end
        pool_mac[0]   = MAC_ZERO;
        pool_short[0] = 16'h0000;
        pool_mac[1]   = MAC_ONES;
        pool_short[1] = 16'hFFFF;
        // A few devices share a short address, so a short-address lookup has
        // to pick the first entry that carries it.
        for (int i = 2; i < 5; i++) begin
            pool_short[i + 12] = pool_short[i];
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, miss limit at its reset value of 3.
        send_scan();                                                  // empty table
        send_beat(KIND_MSG, 8'h01, 1'b1, MAC_C, 16'h1111);            // ignored
        send_beat(KIND_MSG, 8'hFF, 1'b1, MAC_C, 16'h1111);            // ignored
        send_beat(KIND_MSG, CMD_DATA_A, 1'b0, MAC_ONES, 16'hFFFF);    // unknown
        send_beat(KIND_MSG, CMD_DATA_A, 1'b1, MAC_ZERO, 16'h0000);    // insert A
        send_beat(KIND_MSG, CMD_DATA_B, 1'b1, MAC_ONES, 16'hFFFF);    // insert B
        send_beat(KIND_MSG, CMD_DATA_A, 1'b1, MAC_C, SHORT_SHARED);   // insert C
        send_beat(KIND_MSG, CMD_DATA_B, 1'b1, MAC_ONES, 16'h0000);    // hit B by mac
        send_beat(KIND_MSG, CMD_DATA_A, 1'b0, MAC_D, SHORT_SHARED);   // hit C by short
        send_beat(KIND_MSG, CMD_DATA_B, 1'b0, MAC_ONES, 16'h0000);    // hit A by short
        send_beat(KIND_MSG, CMD_DATA_A, 1'b1, MAC_D, SHORT_SHARED);   // insert D
        send_beat(KIND_MSG, CMD_DATA_B, 1'b0, MAC_ZERO, SHORT_SHARED);// first match is C
        send_scan();                                                  // D starts missing
        send_beat(KIND_MSG, CMD_DATA_A, 1'b1, MAC_C, 16'h0000);
        send_scan();
        send_beat(KIND_MSG, CMD_DATA_B, 1'b0, MAC_ONES, SHORT_SHARED);
        send_scan();                                                  // D goes, tail
        send_scan();                                                  // A and B go, head
        send_beat(KIND_MSG, CMD_DATA_B, 1'b0, MAC_ONES, 16'h0000);    // A is unknown now

        // Random phases, each opened by a new miss limit once the block is idle.
        wait_idle();
        write_limit(8'd1);
        random_traffic(60, 15);

        wait_idle();
        write_limit(8'd255);
        random_traffic(90, 5);

        wait_idle();
        write_limit(8'd0);
        random_traffic(14, 40);

        wait_idle();
        write_limit(8'd3);
        random_traffic(90, 15);

        wait_idle();
        write_limit(8'($urandom_range(2, 6)));
        random_traffic(110, 18);

        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d input beats across %0d miss limit settings.",
                 items_sent, limit_writes);
        $display("Checked %0d result beats, %0d of them entry removals.",
                 checked, removals);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(6_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
design/dlt_pkg.sv
design/dlt_msg_if.sv
design/dlt_res_if.sv
design/dlt_cfg_if.sv
design/dlt_entry_ram.sv
design/device_liveness_table.sv
design/dlt_checker.sv
bench/dlt_liveness_check.sv
bench/tb.sv
